>>> src/rv32ie_pkg.sv
// Shared types and constants of the RV32I instruction executor.
// Opcodes, halt causes and the structs passed between the modules.
// No dependencies.
`timescale 1ns / 1ps

package rv32ie_pkg;

  localparam logic [6:0] OPC_MASK   = 7'h7F;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUR   = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [31:0] LUI_MASK  = 32'hFFFFF000;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_ECALL     = 3'd1,
    CAUSE_BOUNDS    = 3'd2,
    CAUSE_MISALIGN  = 3'd3,
    CAUSE_LOAD_SIZE = 3'd4
  } halt_cause_t;

  // Data memory request issued by the execute stage.
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [31:0] addr;
    logic [2:0]  nbytes;
    logic [31:0] wdata;
  } mem_req_t;

  // Outcome of one instruction leaving the execute stage.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        is_load;
    logic [2:0]  ld_f3;
    logic [1:0]  ld_ofs;
    logic        halted;
    halt_cause_t cause;
  } exe_t;

endpackage

>>> src/rv32ie_regfile.sv
// Register file: 32 x 32 bits, one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps

module rv32ie_regfile (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [4:0]  ra,
  input  logic [4:0]  rb,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] qa_r,
  output logic [31:0] qb_r
);

  logic [31:0] regs [32];

  always_ff @(posedge clk) begin
    if (we) begin
      regs[wa] <= wd;
    end
    if (rd_en) begin
      qa_r <= regs[ra];
      qb_r <= regs[rb];
    end
  end

endmodule

>>> src/rv32ie_dmem.sv
// Byte-addressed data memory as four byte banks, little-endian, any alignment.
// Depends on rv32ie_pkg.
`timescale 1ns / 1ps

module rv32ie_dmem #(
  parameter int WORDS = 16384,
  parameter int RW    = 14
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  clr_en,
  input  logic [RW-1:0]         clr_row,
  input  rv32ie_pkg::mem_req_t  req,
  output logic [3:0][7:0]       rdata_r
);
  import rv32ie_pkg::*;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [WORDS];
    logic [1:0]    bidx;
    logic [RW+1:0] sum;
    logic [RW-1:0] row;
    logic          wr_k;
    logic [7:0]    wd_k;

    always_comb begin
      bidx = 2'(k) - req.addr[1:0];
      sum  = req.addr[RW+1:0] + (RW+2)'(bidx);
      row  = sum[RW+1:2];
      wr_k = req.wr_en && ({1'b0, bidx} < req.nbytes);
      wd_k = req.wdata[8*bidx +: 8];
    end

    always_ff @(posedge clk) begin
      if (clr_en) begin
        mem[clr_row] <= 8'd0;
      end else if (en && wr_k) begin
        mem[row] <= wd_k;
      end
      if (en) begin
        rdata_r[k] <= mem[row];
      end
    end
  end

endmodule

>>> src/rv32ie_exec.sv
// Execute stage: decode, ALU, branch and jump targets, memory request, halt.
// Depends on rv32ie_pkg.
`timescale 1ns / 1ps

module rv32ie_exec #(
  parameter int MEMORY_BYTES = 65536
) (
  input  logic [31:0]           instr,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  input  logic [31:0]           pc,
  input  logic                  stopped,
  output rv32ie_pkg::exe_t      res,
  output rv32ie_pkg::mem_req_t  req
);
  import rv32ie_pkg::*;

  localparam logic [32:0] MEM_END = 33'(MEMORY_BYTES);

  logic [6:0]  opc;
  logic [6:0]  f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, y, pc4, addr;
  logic [2:0]  nb;
  logic        oob, take, ok;

  always_comb begin
    opc   = instr[6:0] & OPC_MASK;
    rd    = instr[11:7];
    f3    = instr[14:12];
    f7    = instr[31:25];
    imm_i = {{20{instr[31]}}, instr[31:20]};
    imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    pc4   = pc + 32'd4;
    y     = (opc == OPC_ALUI) ? imm_i : b;
    sh    = (opc == OPC_ALUI) ? instr[24:20] : b[4:0];
    addr  = a + ((opc == OPC_STORE) ? imm_s : imm_i);
    if (opc == OPC_STORE) begin
      nb = (f3 == F3_H) ? 3'd2 : ((f3 == F3_W) ? 3'd4 : 3'd1);
    end else begin
      nb = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
    end
    oob  = ({1'b0, addr} + 33'(nb)) > MEM_END;
    take = 1'b0;
    ok   = 1'b1;

    res         = '0;
    res.next_pc = pc4;
    res.rd      = rd;
    res.ld_f3   = f3;
    res.ld_ofs  = addr[1:0];
    res.cause   = CAUSE_NONE;
    req         = '0;
    req.addr    = addr;
    req.nbytes  = nb;
    req.wdata   = b;

    if (stopped) begin
      res.next_pc = pc;
    end else begin
      case (opc)
        OPC_LOAD: begin
          if (rd != 5'd0) begin
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
              res.cause = CAUSE_LOAD_SIZE;
            end else if (oob) begin
              res.cause = CAUSE_BOUNDS;
            end else begin
              req.rd_en   = 1'b1;
              res.is_load = 1'b1;
              res.wr      = 1'b1;
            end
          end
        end
        OPC_ALUI, OPC_ALUR: begin
          case (f3)
            3'd0: begin
              if (opc == OPC_ALUI || f7 == F7_BASE) res.val = a + y;
              else if (f7 == F7_ALT) res.val = a - y;
              else ok = 1'b0;
            end
            3'd1: res.val = a << sh;
            3'd2: res.val = {31'd0, $signed(a) < $signed(y)};
            3'd3: res.val = {31'd0, a < y};
            3'd4: res.val = a ^ y;
            3'd5: begin
              if (f7 == F7_BASE) res.val = a >> sh;
              else if (f7 == F7_ALT) res.val = 32'($signed(a) >>> sh);
              else ok = 1'b0;
            end
            3'd6: res.val = a | y;
            default: res.val = a & y;
          endcase
          res.wr = ok && (rd != 5'd0);
        end
        OPC_STORE: begin
          if (oob) begin
            res.cause = CAUSE_BOUNDS;
          end else if (f3 == F3_H && addr[0]) begin
            res.cause = CAUSE_MISALIGN;
          end else if (f3 <= F3_W) begin
            req.wr_en = 1'b1;
          end
        end
        OPC_LUI: begin
          res.val = instr & LUI_MASK;
          res.wr  = rd != 5'd0;
        end
        OPC_BRANCH: begin
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 1'b0;
          endcase
          if (take) res.next_pc = pc + imm_b;
        end
        OPC_JAL, OPC_JALR: begin
          if (opc == OPC_JAL) res.next_pc = pc + imm_j;
          else res.next_pc = (a + imm_i) & ~32'd1;
          res.val = pc4;
          res.wr  = rd != 5'd0;
          if (res.next_pc >= 32'(MEMORY_BYTES)) res.cause = CAUSE_BOUNDS;
        end
        OPC_SYSTEM: res.cause = CAUSE_ECALL;
        default: ;
      endcase
      if (res.cause != CAUSE_NONE && opc != OPC_JAL && opc != OPC_JALR) begin
        res.next_pc = pc;
      end
    end
    res.halted = stopped || (res.cause != CAUSE_NONE);
  end

endmodule

>>> src/rv32i_instruction_executor.sv
// Top level of the RV32I instruction executor: pipeline, forwarding, clear pass.
// Depends on rv32ie_pkg, rv32ie_regfile, rv32ie_dmem and rv32ie_exec.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_instruction
// out_      output     out_valid / out_stall out_next_pc, out_wrote_register,
//                                            out_dest_index, out_dest_value,
//                                            out_halted, out_halt_cause
//
// One request per cycle sustained while no result is stalled. An accepted request
// has its operands read at the accepting edge, then passes execute plus memory
// access, then write-back into the result register.
// After reset the block clears memory and registers, one memory row of four
// bytes per cycle, with in_stall high until every row is cleared.
// A stalled result holds the whole pipeline; the stages behind it keep their
// requests, and one new request is taken for each result taken.

module rv32i_instruction_executor #(
  parameter int MEMORY_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_wrote_register,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_halted,
  output logic [2:0]  out_halt_cause
);
  import rv32ie_pkg::*;

  localparam int WORDS = (MEMORY_BYTES + 3) / 4;
  localparam int RW    = $clog2(WORDS);
  localparam logic [RW-1:0] LAST_ROW = RW'(WORDS - 1);

  // Pipeline advance: everything moves when the result register is empty or being taken.
  logic en;

  // Clear pass after reset.
  logic          clr_r;
  logic [RW-1:0] clr_cnt_r;

  // Architectural state.
  logic [31:0] pc_r;
  logic        stopped_r;

  // Execute stage.
  logic        s1_v_r;
  logic [31:0] s1_ins_r;
  logic [31:0] rf_a, rf_b, op_a, op_b;
  exe_t        exe;
  mem_req_t    req, req_q;

  // Write-back stage.
  logic        s2_v_r;
  exe_t        s2_r;
  logic [3:0][7:0] mem_q;
  logic [31:0] ld_raw, ld_val, s2_val;
  logic        s2_wr;

  // Last register write, covers the read that races it.
  logic        lw_v_r;
  logic [4:0]  lw_idx_r;
  logic [31:0] lw_val_r;

  // Result register.
  logic        out_v_r;
  logic [31:0] out_pc_r, out_val_r;
  logic        out_wr_r, out_halt_r;
  logic [4:0]  out_idx_r;
  logic [2:0]  out_cause_r;

  assign en       = !(out_v_r && out_stall);
  assign in_stall = !en || clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + RW'(1);
      if (clr_cnt_r == LAST_ROW) clr_r <= 1'b0;
    end
  end

  rv32ie_regfile u_rf (
    .clk   (clk),
    .rd_en (en),
    .ra    (in_instruction[19:15]),
    .rb    (in_instruction[24:20]),
    .we    (clr_r || (en && s2_wr)),
    .wa    (clr_r ? clr_cnt_r[4:0] : s2_r.rd),
    .wd    (clr_r ? 32'd0 : s2_val),
    .qa_r  (rf_a),
    .qb_r  (rf_b)
  );

  // Forward: the write-back stage first, then the write that just landed.
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (lw_v_r && lw_idx_r == s1_ins_r[19:15]) op_a = lw_val_r;
    if (lw_v_r && lw_idx_r == s1_ins_r[24:20]) op_b = lw_val_r;
    if (s2_wr && s2_r.rd == s1_ins_r[19:15]) op_a = s2_val;
    if (s2_wr && s2_r.rd == s1_ins_r[24:20]) op_b = s2_val;
  end

  rv32ie_exec #(.MEMORY_BYTES(MEMORY_BYTES)) u_exec (
    .instr   (s1_ins_r),
    .a       (op_a),
    .b       (op_b),
    .pc      (pc_r),
    .stopped (stopped_r),
    .res     (exe),
    .req     (req)
  );

  // Drop the store when the stage holds no request.
  always_comb begin
    req_q       = req;
    req_q.wr_en = req.wr_en && s1_v_r;
  end

  rv32ie_dmem #(.WORDS(WORDS), .RW(RW)) u_dmem (
    .clk     (clk),
    .en      (en),
    .clr_en  (clr_r),
    .clr_row (clr_cnt_r),
    .req     (req_q),
    .rdata_r (mem_q)
  );

  // Assemble the load bytes, little-endian from the access offset.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_raw[8*i +: 8] = mem_q[2'(i) + s2_r.ld_ofs];
    end
    case (s2_r.ld_f3)
      F3_B:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      F3_H:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      F3_BU:   ld_val = {24'd0, ld_raw[7:0]};
      F3_HU:   ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
    s2_val = s2_r.is_load ? ld_val : s2_r.val;
    s2_wr  = s2_v_r && s2_r.wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      stopped_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      lw_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid && !clr_r;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
      lw_v_r  <= s2_wr;
      if (s1_v_r) begin
        pc_r      <= exe.next_pc;
        stopped_r <= exe.halted;
      end
    end
  end

  // Payload registers advance with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ins_r    <= in_instruction;
      s2_r        <= exe;
      lw_idx_r    <= s2_r.rd;
      lw_val_r    <= s2_val;
      out_pc_r    <= s2_r.next_pc;
      out_wr_r    <= s2_r.wr;
      out_idx_r   <= s2_r.wr ? s2_r.rd : 5'd0;
      out_val_r   <= s2_r.wr ? s2_val : 32'd0;
      out_halt_r  <= s2_r.halted;
      out_cause_r <= s2_r.cause;
    end
  end

  assign out_valid          = out_v_r;
  assign out_next_pc        = out_pc_r;
  assign out_wrote_register = out_wr_r;
  assign out_dest_index     = out_idx_r;
  assign out_dest_value     = out_val_r;
  assign out_halted         = out_halt_r;
  assign out_halt_cause     = out_cause_r;

endmodule

>>> verif/tb_rv32i_instruction_executor.sv
// Testbench for rv32i_instruction_executor: drives RV32I words, predicts results.
// Depends on rv32ie_pkg and the executor RTL only.
`timescale 1ns / 1ps

module tb_rv32i_instruction_executor;
  import rv32ie_pkg::*;

  localparam int MEM_BYTES = 65536;

  // funct3 codes of the ALU, branch and load groups
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SR   = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;
  localparam logic [2:0] ALU_AND  = 3'd7;
  localparam logic [2:0] BR_EQ    = 3'd0;
  localparam logic [2:0] BR_NE    = 3'd1;
  localparam logic [2:0] BR_BAD2  = 3'd2;
  localparam logic [2:0] BR_LT    = 3'd4;
  localparam logic [2:0] BR_GE    = 3'd5;
  localparam logic [2:0] BR_LTU   = 3'd6;
  localparam logic [2:0] BR_GEU   = 3'd7;
  localparam logic [2:0] LD_BAD   = 3'd7;

  typedef struct {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        halted;
    halt_cause_t cause;
  } retire_t;

  // Architectural shadow of the core plus the queue of outstanding retirements.
  class retire_board;
    bit [31:0]   regs [32];
    bit [7:0]    mem [MEM_BYTES];
    bit [31:0]   pc;
    bit          stopped;
    retire_t     pending_q [$];
    int          errors;
    int          accepted;
    int          retired;

    // Execute one word; with commit clear, state is left untouched.
    function void execute(input logic [31:0] ins, input bit commit, output retire_t r);
      logic [6:0]  opc;
      logic [4:0]  rd, rs1, rs2, sh;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a, b, imm_i, npc, addr, val, off, y;
      logic [63:0] last;
      int          n;
      bit          wr, take, ok;
      halt_cause_t cause;
      opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
      rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
      a = regs[rs1]; b = regs[rs2];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      npc = pc + 32'd4; wr = 0; val = '0; cause = CAUSE_NONE;
      if (stopped) begin
        npc = pc;
      end else if (opc == OPC_LOAD) begin
        if (rd != 0) begin
          addr = a + imm_i;
          n = (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
          last = {32'd0, addr} + n;
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == LD_BAD) begin
            cause = CAUSE_LOAD_SIZE;
          end else if (last > MEM_BYTES) begin
            cause = CAUSE_BOUNDS;
          end else begin
            for (int i = 0; i < n; i++) val |= 32'(mem[addr + i]) << (8 * i);
            if (f3 == F3_B) val = {{24{val[7]}}, val[7:0]};
            else if (f3 == F3_H) val = {{16{val[15]}}, val[15:0]};
            wr = 1;
          end
        end
      end else if (opc == OPC_ALUI || opc == OPC_ALUR) begin
        y = (opc == OPC_ALUI) ? imm_i : b;
        sh = (opc == OPC_ALUI) ? rs2 : b[4:0];
        ok = 1;
        case (f3)
          ALU_ADD:
            if (opc == OPC_ALUI || f7 == F7_BASE) val = a + y;
            else if (f7 == F7_ALT) val = a - y;
            else ok = 0;
          ALU_SLL:  val = a << sh;
          ALU_SLT:  val = ($signed(a) < $signed(y)) ? 32'd1 : 32'd0;
          ALU_SLTU: val = (a < y) ? 32'd1 : 32'd0;
          ALU_XOR:  val = a ^ y;
          ALU_SR:
            if (f7 == F7_BASE) val = a >> sh;
            else if (f7 == F7_ALT) val = $unsigned($signed(a) >>> sh);
            else ok = 0;
          ALU_OR:   val = a | y;
          default:  val = a & y;
        endcase
        wr = ok && rd != 0;
      end else if (opc == OPC_STORE) begin
        addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
        n = (f3 == F3_H) ? 2 : ((f3 == F3_W) ? 4 : 1);
        last = {32'd0, addr} + n;
        if (last > MEM_BYTES) cause = CAUSE_BOUNDS;
        else if (f3 == F3_H && addr[0]) cause = CAUSE_MISALIGN;
        else if (f3 <= F3_W && commit)
          for (int i = 0; i < n; i++) mem[addr + i] = b[8 * i +: 8];
      end else if (opc == OPC_LUI) begin
        val = ins & LUI_MASK;
        wr = rd != 0;
      end else if (opc == OPC_BRANCH) begin
        off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        case (f3)
          BR_EQ:   take = a == b;
          BR_NE:   take = a != b;
          BR_LT:   take = $signed(a) < $signed(b);
          BR_GE:   take = $signed(a) >= $signed(b);
          BR_LTU:  take = a < b;
          BR_GEU:  take = a >= b;
          default: take = 0;
        endcase
        if (take) npc = pc + off;
      end else if (opc == OPC_JAL || opc == OPC_JALR) begin
        if (opc == OPC_JAL)
          npc = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        else
          npc = (a + imm_i) & ~32'd1;
        val = pc + 32'd4;
        wr = rd != 0;
        if (npc >= MEM_BYTES) cause = CAUSE_BOUNDS;
      end else if (opc == OPC_SYSTEM) begin
        cause = CAUSE_ECALL;
      end
      if (cause != CAUSE_NONE) begin
        wr = 0;
        if (opc != OPC_JAL && opc != OPC_JALR) npc = pc;
      end
      // JAL/JALR that halt still link
      if (cause != CAUSE_NONE && (opc == OPC_JAL || opc == OPC_JALR)) wr = rd != 0;
      r.next_pc = npc;
      r.wr = wr;
      r.rd = wr ? rd : 5'd0;
      r.val = wr ? val : 32'd0;
      r.halted = stopped || cause != CAUSE_NONE;
      r.cause = cause;
      if (commit) begin
        if (wr) regs[rd] = val;
        regs[0] = '0;
        pc = npc;
        if (cause != CAUSE_NONE) stopped = 1;
      end
    endfunction

    function void note_request(input logic [31:0] ins);
      retire_t r;
      execute(ins, 1, r);
      pending_q.push_back(r);
      accepted++;
    endfunction

    function void check_result(input retire_t got);
      retire_t e;
      retired++;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding: next_pc %h", got.next_pc);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.wr !== e.wr) begin
        $error("wrote_register exp %b got %b", e.wr, got.wr); errors++;
      end
      if (got.rd !== e.rd) begin
        $error("dest_index exp %0d got %0d", e.rd, got.rd); errors++;
      end
      if (got.val !== e.val) begin
        $error("dest_value exp %h got %h", e.val, got.val); errors++;
      end
      if (got.halted !== e.halted) begin
        $error("halted exp %b got %b", e.halted, got.halted); errors++;
      end
      if (got.cause !== e.cause) begin
        $error("halt_cause exp %0d got %0d", e.cause, got.cause); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instruction;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_next_pc;
  logic        out_wrote_register;
  logic [4:0]  out_dest_index;
  logic [31:0] out_dest_value;
  logic        out_halted;
  logic [2:0]  out_halt_cause;

  retire_board board = new();
  int          burst_left;

  rv32i_instruction_executor #(.MEMORY_BYTES(MEM_BYTES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_instruction(in_instruction),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_pc(out_next_pc), .out_wrote_register(out_wrote_register),
    .out_dest_index(out_dest_index), .out_dest_value(out_dest_value),
    .out_halted(out_halted), .out_halt_cause(out_halt_cause)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Safety net: clear pass plus ~1000 requests with gaps and stalls.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Encoders for the standard instruction formats.
  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_ALUR};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] off);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  // Offer one request and hold it until the core takes it; valid stays high on return.
  task automatic send_request(input logic [31:0] ins);
    in_valid <= 1'b1;
    in_instruction <= ins;
    do @(posedge clk); while (in_stall);
    board.note_request(ins);
  endtask

  // Burst/gap pacing: drop valid only between bursts.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_instruction <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Draw one random instruction that keeps the core running.
  function automatic logic [31:0] draw_running();
    logic [31:0] ins;
    logic [4:0]  base;
    retire_t     probe;
    for (int t = 0; t < 50; t++) begin
      base = 5'($urandom_range(1, 4));
      case ($urandom_range(0, 99)) inside
        [0:14]:  ins = enc_i(OPC_ALUI, base, ALU_ADD, 5'd0, 12'($urandom_range(0, 2047)));
        [15:34]: ins = enc_i(OPC_LOAD, 5'($urandom()), 3'($urandom()), base, 12'($urandom()));
        [35:49]: ins = enc_s(3'($urandom()), 5'($urandom()), base, 12'($urandom()));
        [50:64]: begin
          ins = enc_i(OPC_ALUI, 5'($urandom()), 3'($urandom()), 5'($urandom()),
                      12'($urandom()));
          if (ins[13:12] == 2'b01 && $urandom_range(0, 2) != 0)
            ins[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        end
        [65:79]: ins = enc_r($urandom_range(0, 4) == 0 ? 7'($urandom()) :
                             ($urandom_range(0, 1) ? F7_ALT : F7_BASE),
                             5'($urandom()), 5'($urandom()), 3'($urandom()), 5'($urandom()));
        [80:84]: ins = {20'($urandom()), 5'($urandom()), OPC_LUI};
        [85:89]: ins = enc_b(3'($urandom()), 5'($urandom()), 5'($urandom()),
                             13'($urandom_range(0, 64)) << 1);
        [90:92]: ins = enc_j(5'($urandom()), 21'($signed(12'($urandom())) <<< 1));
        [93:94]: ins = enc_i(OPC_JALR, 5'($urandom()), 3'($urandom()), base, 12'($urandom()));
        default: ins = $urandom();
      endcase
      board.execute(ins, 0, probe);
      if (!probe.halted) return ins;
    end
    return enc_i(OPC_ALUI, 5'd0, ALU_ADD, 5'd0, 12'd0);
  endfunction

  // Receiver: random stall pattern, with one long hold mid-run to back the core up.
  initial begin
    bit held;
    out_stall <= 1'b1;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && board.accepted >= 300) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'b1;
        default: out_stall <= $urandom_range(0, 2) == 0;
      endcase
    end
  end

  // Retirement monitor.
  always @(posedge clk) begin
    retire_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.next_pc = out_next_pc;
      got.wr = out_wrote_register;
      got.rd = out_dest_index;
      got.val = out_dest_value;
      got.halted = out_halted;
      got.cause = halt_cause_t'(out_halt_cause);
      board.check_result(got);
    end
  end

  initial begin
    logic [31:0] directed [$];
    int          wait_cycles;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_instruction <= '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: address setup, bytewise stores and loads, ALU ops but XOR, OR and AND, control flow.
    directed = '{
      enc_i(OPC_ALUI, 5'd1, ALU_ADD, 5'd0, 12'd256),
      enc_i(OPC_ALUI, 5'd2, ALU_ADD, 5'd0, 12'hFFF),
      {20'h80000, 5'd3, OPC_LUI},
      enc_i(OPC_ALUI, 5'd4, ALU_ADD, 5'd0, 12'd31),
      enc_s(F3_W, 5'd2, 5'd1, 12'd1),
      enc_s(F3_H, 5'd3, 5'd1, 12'd6),
      enc_s(F3_B, 5'd4, 5'd1, 12'd3),
      enc_i(OPC_LOAD, 5'd5, F3_W, 5'd1, 12'd1),
      enc_i(OPC_LOAD, 5'd6, F3_H, 5'd1, 12'd3),
      enc_i(OPC_LOAD, 5'd7, F3_HU, 5'd1, 12'd2),
      enc_i(OPC_LOAD, 5'd8, F3_B, 5'd1, 12'd2),
      enc_i(OPC_LOAD, 5'd9, F3_BU, 5'd1, 12'd2),
      enc_i(OPC_LOAD, 5'd0, LD_BAD, 5'd2, 12'hFFF),
      enc_r(F7_ALT, 5'd2, 5'd3, ALU_ADD, 5'd10),
      enc_r(F7_BASE, 5'd4, 5'd2, ALU_SLL, 5'd11),
      enc_r(F7_BASE, 5'd3, 5'd2, ALU_SLT, 5'd12),
      enc_r(F7_BASE, 5'd2, 5'd1, ALU_SLTU, 5'd13),
      enc_r(F7_ALT, 5'd4, 5'd3, ALU_SR, 5'd14),
      enc_r(F7_BASE, 5'd4, 5'd3, ALU_SR, 5'd15),
      enc_r(7'h01, 5'd4, 5'd3, ALU_SR, 5'd16),
      enc_i(OPC_ALUI, 5'd17, ALU_SLT, 5'd2, 12'h800),
      enc_b(BR_EQ, 5'd0, 5'd0, 13'd8),
      enc_b(BR_BAD2, 5'd0, 5'd0, 13'd8),
      enc_j(5'd18, 21'd8),
      enc_i(OPC_JALR, 5'd19, 3'd0, 5'd1, 12'hF01)
    };
    foreach (directed[k]) begin
      send_request(directed[k]);
      pace();
    end

    // Random: mostly well-formed programs that stay running.
    repeat (900) begin
      send_request(draw_running());
      pace();
    end

    // Stop the core once, by a randomly chosen cause, then show it ignores requests.
    case ($urandom_range(0, 3))
      0: send_request({25'($urandom()), OPC_SYSTEM});
      1: begin
        send_request({20'hFFFFF, 5'd30, OPC_LUI});
        send_request(enc_i(OPC_LOAD, 5'd5, F3_W, 5'd30, 12'd0));
      end
      2: begin
        send_request(enc_i(OPC_ALUI, 5'd30, ALU_ADD, 5'd0, 12'd1));
        send_request(enc_s(F3_H, 5'd0, 5'd30, 12'd0));
      end
      default: send_request(enc_i(OPC_LOAD, 5'd5, LD_BAD, 5'd0, 12'd0));
    endcase
    repeat (5) send_request($urandom());
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (board.pending_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    $display("Ran %0d requests (directed, random programs, final halt); %0d results checked.",
             board.accepted, board.retired);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
